[hw/rtl/slm_pkg.sv]
package slm_pkg;

    // Default width of the linear level words
    localparam int LEVEL_BITS_DEF = 16;

    localparam int FIELD_BITS     = 16;
    localparam int GAIN_BITS      = 16;
    localparam int HOLD_BITS      = 8;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 2;

    // 80 dB in Q8.8: the magnitude of the -80 dB bottom of the meter scale
    localparam int FLOOR_Q88   = 20480;
    // Fraction bits of the reciprocal used for the dB to linear mapping
    localparam int RECIP_SHIFT = 15;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAST_GAIN    = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SLOW_GAIN    = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_HOLD_UPDATES = 2'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECAY_STEP   = 2'd3;

    // Reset values of the registers
    localparam logic [GAIN_BITS-1:0]     FAST_GAIN_RST    = 16'd22938;
    localparam logic [GAIN_BITS-1:0]     SLOW_GAIN_RST    = 16'd6554;
    localparam logic [HOLD_BITS-1:0]     HOLD_UPDATES_RST = 8'd45;
    localparam logic [CFG_DATA_BITS-1:0] DECAY_STEP_RST   = 16'd328;

    typedef struct packed {
        logic signed [FIELD_BITS-1:0] peak_db_left;
        logic signed [FIELD_BITS-1:0] peak_db_right;
        logic signed [FIELD_BITS-1:0] rms_db_left;
        logic signed [FIELD_BITS-1:0] rms_db_right;
    } update_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] peak_level_left;
        logic [FIELD_BITS-1:0] peak_level_right;
        logic [FIELD_BITS-1:0] rms_level_left;
        logic [FIELD_BITS-1:0] rms_level_right;
        logic [FIELD_BITS-1:0] held_peak_left;
        logic [FIELD_BITS-1:0] held_peak_right;
        logic [FIELD_BITS-1:0] mean_rms;
    } result_t;

endpackage

[hw/rtl/slm_chan_if.sv]
interface slm_chan_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/slm_mul.sv]
module slm_mul #(
    parameter int A_BITS = 17,
    parameter int B_BITS = 16
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic [A_BITS-1:0]          a,
    input  logic [B_BITS-1:0]          b,
    output logic [A_BITS+B_BITS-1:0]   p
);

    logic [A_BITS+B_BITS-1:0] p_reg;

    // Register the product; hold it while idle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= (A_BITS+B_BITS)'(a) * (A_BITS+B_BITS)'(b);
        end
    end

    assign p = p_reg;

endmodule

[hw/rtl/stereo_level_meter_peak_hold.sv]
// Stereo level meter with VU-style ballistics and a peak hold marker.
//
// Channels: "update" (sink) takes one request holding peak and RMS levels in
// dB, Q8.8, for left and right. "result" (source) returns one request per
// update: smoothed peaks, smoothed RMS levels, held peaks and the mean RMS,
// all linear unsigned Q0.LEVEL_BITS, truncated to 16 bits.
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// writes take effect at once and are meant for idle periods only.
//
// Timing: one shared multiplier does all the multiplications. Each of the four
// levels passes a multiply and a fix-up state for the dB to linear mapping and
// a multiply and an apply state for the smoothing step, then the hold state
// updates both peak holds and the final state loads the result register.
// The result becomes valid and update.ready returns in the same cycle, so a new
// update is taken only after the last one's result has been loaded.
//
// Reset clears all smoothed levels, holds and counters to zero and restores
// the register defaults. If the receiver stalls, the result register holds
// and the next update may still be taken and processed; its result then
// waits in the final step until the pending result is taken.
module stereo_level_meter_peak_hold #(
    parameter int LEVEL_BITS = slm_pkg::LEVEL_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    slm_chan_if.sink                             update,
    slm_chan_if.source                           result,
    input  logic                                 cfg_we,
    input  logic [slm_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [slm_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

    localparam int LB = LEVEL_BITS;
    localparam int MA = LB + 1;
    localparam int MB = slm_pkg::GAIN_BITS;
    localparam int PW = MA + MB;
    localparam int DW = (LB > slm_pkg::CFG_DATA_BITS) ? LB : slm_pkg::CFG_DATA_BITS;
    localparam int FB = slm_pkg::FIELD_BITS;
    localparam int RS = slm_pkg::RECIP_SHIFT;

    // floor(2^(LB+RS) / 20480): level = (x * RECIP) >> RS, off by at most one
    localparam logic [63:0] RECIP_WIDE =
        (64'd1 << (LEVEL_BITS + slm_pkg::RECIP_SHIFT)) / 64'(slm_pkg::FLOOR_Q88);
    localparam logic [MA-1:0] RECIP = MA'(RECIP_WIDE);
    localparam logic [LB-1:0] LEVEL_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CONV_MUL,
        ST_CONV_FIX,
        ST_SMOOTH_MUL,
        ST_SMOOTH_APPLY,
        ST_HOLD,
        ST_DONE
    } state_t;

    state_t state_reg;
    logic [1:0] k_reg;

    // Index order: peak left, peak right, rms left, rms right
    logic signed [FB-1:0] db_reg [4];
    logic [LB-1:0] lin_reg [4];
    logic [LB-1:0] smooth_reg [4];
    logic [LB-1:0] hold_level_reg [2];
    logic [slm_pkg::HOLD_BITS-1:0] hold_count_reg [2];

    logic [slm_pkg::GAIN_BITS-1:0] fast_gain_reg;
    logic [slm_pkg::GAIN_BITS-1:0] slow_gain_reg;
    logic [slm_pkg::HOLD_BITS-1:0] hold_updates_reg;
    logic [slm_pkg::CFG_DATA_BITS-1:0] decay_step_reg;

    slm_pkg::result_t res_reg;
    logic res_valid_reg;

    logic signed [FB-1:0] db_cur;
    logic signed [FB:0] x_cur;
    logic [RS-1:0] x_u;
    logic x_floor;
    logic [LB-1:0] q_est;
    logic [LB:0] q_inc;
    logic [LB+15:0] q_scaled;
    logic [LB+15:0] x_scaled;
    logic [LB-1:0] lin_fix;

    logic [LB-1:0] lin_cur;
    logic [LB-1:0] s_cur;
    logic [slm_pkg::GAIN_BITS-1:0] gain_cur;
    logic up;
    logic [LB-1:0] diff;
    logic [LB-1:0] step;
    logic [LB-1:0] s_next;

    logic [LB-1:0] hold_level_next [2];
    logic [slm_pkg::HOLD_BITS-1:0] hold_count_next [2];
    logic [LB:0] rms_sum;

    logic mul_en;
    logic [MA-1:0] mul_a;
    logic [MB-1:0] mul_b;
    logic [PW-1:0] prod;

    logic load_result;

    slm_mul #(
        .A_BITS(MA),
        .B_BITS(MB)
    ) u_mul (
        .clk(clk),
        .en(mul_en),
        .a(mul_a),
        .b(mul_b),
        .p(prod)
    );

    // dB to linear: x = dB + 80 dB, level = x * 2^LB / 20480
    always_comb
    begin
        db_cur   = db_reg[k_reg];
        x_cur    = (FB+1)'(db_cur) + (FB+1)'(slm_pkg::FLOOR_Q88);
        x_u      = x_cur[RS-1:0];
        x_floor  = x_cur[FB] || (x_cur == '0);
        q_est    = prod[LB+RS-1:RS];
        q_inc    = (LB+1)'(q_est) + (LB+1)'(1);
        q_scaled = (LB+16)'({q_inc, 14'b0}) + (LB+16)'({q_inc, 12'b0});
        x_scaled = (LB+16)'({x_u, {LB{1'b0}}});
        if (!db_cur[FB-1])
        begin
            lin_fix = LEVEL_MAX;
        end
        else if (x_floor)
        begin
            lin_fix = '0;
        end
        else if (q_scaled <= x_scaled)
        begin
            lin_fix = LB'(q_inc);
        end
        else
        begin
            lin_fix = q_est;
        end
    end

    // Exponential smoothing: move toward the target by gain * |x - s| >> 16
    always_comb
    begin
        lin_cur  = lin_reg[k_reg];
        s_cur    = smooth_reg[k_reg];
        gain_cur = k_reg[1] ? slow_gain_reg : fast_gain_reg;
        up       = (lin_cur >= s_cur);
        diff     = up ? (lin_cur - s_cur) : (s_cur - lin_cur);
        step     = prod[LB+15:16];
        s_next   = up ? (s_cur + step) : (s_cur - step);
    end

    // Feed the shared multiplier
    always_comb
    begin
        mul_en = (state_reg == ST_CONV_MUL) || (state_reg == ST_SMOOTH_MUL);
        if (state_reg == ST_SMOOTH_MUL)
        begin
            mul_a = MA'(diff);
            mul_b = gain_cur;
        end
        else
        begin
            mul_a = RECIP;
            mul_b = MB'(x_u);
        end
    end

    // Peak hold: relatch on a new peak, count down, then decay to zero
    always_comb
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            hold_level_next[ch] = hold_level_reg[ch];
            hold_count_next[ch] = hold_count_reg[ch];
            if (lin_reg[ch] >= hold_level_reg[ch])
            begin
                hold_level_next[ch] = lin_reg[ch];
                hold_count_next[ch] = hold_updates_reg;
            end
            else if (hold_count_reg[ch] != '0)
            begin
                hold_count_next[ch] = hold_count_reg[ch] - (slm_pkg::HOLD_BITS)'(1);
            end
            else if (DW'(hold_level_reg[ch]) > DW'(decay_step_reg))
            begin
                hold_level_next[ch] = LB'(DW'(hold_level_reg[ch]) - DW'(decay_step_reg));
            end
            else
            begin
                hold_level_next[ch] = '0;
            end
        end
        rms_sum = (LB+1)'(smooth_reg[2]) + (LB+1)'(smooth_reg[3]);
    end

    assign load_result = (state_reg == ST_DONE) && (!res_valid_reg || result.ready);

    assign update.ready = (state_reg == ST_IDLE);
    assign result.valid = res_valid_reg;
    assign result.data  = res_reg;

    // Capture the request payload; hold linear levels between phases
    always_ff @(posedge clk)
    begin
        if (update.valid && update.ready)
        begin
            db_reg[0] <= update.data.peak_db_left;
            db_reg[1] <= update.data.peak_db_right;
            db_reg[2] <= update.data.rms_db_left;
            db_reg[3] <= update.data.rms_db_right;
        end
        if (state_reg == ST_CONV_FIX)
        begin
            lin_reg[k_reg] <= lin_fix;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            k_reg            <= '0;
            res_valid_reg    <= 1'b0;
            res_reg          <= '0;
            fast_gain_reg    <= slm_pkg::FAST_GAIN_RST;
            slow_gain_reg    <= slm_pkg::SLOW_GAIN_RST;
            hold_updates_reg <= slm_pkg::HOLD_UPDATES_RST;
            decay_step_reg   <= slm_pkg::DECAY_STEP_RST;
            for (int i = 0; i < 4; i++)
            begin
                smooth_reg[i] <= '0;
            end
            for (int ch = 0; ch < 2; ch++)
            begin
                hold_level_reg[ch] <= '0;
                hold_count_reg[ch] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    slm_pkg::REG_FAST_GAIN:    fast_gain_reg    <= cfg_data;
                    slm_pkg::REG_SLOW_GAIN:    slow_gain_reg    <= cfg_data;
                    slm_pkg::REG_HOLD_UPDATES: hold_updates_reg <= cfg_data[slm_pkg::HOLD_BITS-1:0];
                    slm_pkg::REG_DECAY_STEP:   decay_step_reg   <= cfg_data;
                    default: ;
                endcase
            end

            // Drop the result once taken, unless a new one replaces it
            if (result.ready && res_valid_reg && !load_result)
            begin
                res_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (update.valid)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_CONV_MUL;
                    end
                end
                ST_CONV_MUL:
                begin
                    state_reg <= ST_CONV_FIX;
                end
                ST_CONV_FIX:
                begin
                    k_reg     <= k_reg + 2'd1;
                    state_reg <= (k_reg == 2'd3) ? ST_SMOOTH_MUL : ST_CONV_MUL;
                end
                ST_SMOOTH_MUL:
                begin
                    state_reg <= ST_SMOOTH_APPLY;
                end
                ST_SMOOTH_APPLY:
                begin
                    smooth_reg[k_reg] <= s_next;
                    k_reg             <= k_reg + 2'd1;
                    state_reg         <= (k_reg == 2'd3) ? ST_HOLD : ST_SMOOTH_MUL;
                end
                ST_HOLD:
                begin
                    for (int ch = 0; ch < 2; ch++)
                    begin
                        hold_level_reg[ch] <= hold_level_next[ch];
                        hold_count_reg[ch] <= hold_count_next[ch];
                    end
                    state_reg <= ST_DONE;
                end
                ST_DONE:
                begin
                    // Wait here while a stalled result still occupies the register
                    if (load_result)
                    begin
                        res_reg.peak_level_left  <= FB'(smooth_reg[0]);
                        res_reg.peak_level_right <= FB'(smooth_reg[1]);
                        res_reg.rms_level_left   <= FB'(smooth_reg[2]);
                        res_reg.rms_level_right  <= FB'(smooth_reg[3]);
                        res_reg.held_peak_left   <= FB'(hold_level_reg[0]);
                        res_reg.held_peak_right  <= FB'(hold_level_reg[1]);
                        res_reg.mean_rms         <= FB'(rms_sum >> 1);
                        res_valid_reg            <= 1'b1;
                        state_reg                <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // A new result appears only from the final step
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result.valid) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

    // Every accepted update starts the conversion at the first level
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (update.valid && update.ready) |=> (state_reg == ST_CONV_MUL && k_reg == 2'd0))
        else $error("accepted update did not start the conversion");

    // The smoothing pass wraps the index back to the first level
    a_hold_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_HOLD) |-> (k_reg == 2'd0))
        else $error("smoothing pass did not cover all four levels");

    // A finished result waits while the previous one is stalled
    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && res_valid_reg && !result.ready) |=>
            (state_reg == ST_DONE && $stable(res_reg)))
        else $error("pending result overwritten under stall");

endmodule
